// ===== src/taylor_series_function_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef TAYLOR_SERIES_FUNCTION_UNIT_ASSERT_SVH
`define TAYLOR_SERIES_FUNCTION_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define TSFU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsfu check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define TSFU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsfu check failed");

`endif

// ===== src/tsfu_pkg.sv =====
// ----------------------------------------------------------------------------
// tsfu_pkg
// Types and codes shared by the Taylor-series function unit.
// ----------------------------------------------------------------------------
package tsfu_pkg;

  localparam int WORD_W = 64;
  localparam int DEN_W  = 18;
  localparam logic [62:0] MAG_MAX = {63{1'b1}};

  localparam logic [1:0] KIND_SIN  = 2'd0;
  localparam logic [1:0] KIND_ATAN = 2'd1;
  localparam logic [1:0] KIND_LOG  = 2'd2;

  localparam logic [1:0] STAT_CONV   = 2'd0;
  localparam logic [1:0] STAT_DOMAIN = 2'd1;
  localparam logic [1:0] STAT_LIMIT  = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] x_value;
  } tsfu_req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } tsfu_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_X2,
    ST_TERM,
    ST_SCALE,
    ST_DEN,
    ST_DIV,
    ST_ROUND
  } tsfu_state_t;

endpackage

// ===== src/taylor_series_function_unit.sv =====
// ----------------------------------------------------------------------------
// taylor_series_function_unit
// Sine, arctangent and natural log by power series on shared units.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req (kind, x_value in Q4.28) and pulse start
//   while busy is low; the request is taken on that edge.
//   Result channel: result_valid is high for exactly one cycle with the
//   rounded, saturated Q4.28 value and a status. The receiver cannot
//   stall it; capture it on that cycle.
//   Config channel: cfg_data carries term_limit, written when cfg_valid and
//   cfg_ready are high. cfg_ready follows !busy. A limit of 0 acts as 1.
// Sequence:
//   Out-of-domain or unused-kind requests answer on the next cycle.
//   Otherwise each multiply state launches the multiplier, runs four
//   32x32 partials plus a fold-in step and ends on done, and the
//   bit-serial divide state launches, shifts out 63 quotient bits and
//   ends on done. A term is a product, a scaling multiply, for sine a
//   denominator multiply, then the divide, for up to term_limit terms,
//   after an x-squared multiply (sine, arctangent) and before a
//   rounding state. The next request is taken once busy drops, on the
//   cycle result_valid is high.
// Reset: rst is synchronous; it returns the sequencer to idle, clears the
//   strobe and sets term_limit to 64.
// ----------------------------------------------------------------------------
module taylor_series_function_unit import tsfu_pkg::*; #(
  parameter int FRAC_BITS      = 28,
  parameter int WORK_FRAC_BITS = 48
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  tsfu_req_t  req,
  output logic       result_valid,
  output tsfu_res_t  result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int SH = WORK_FRAC_BITS - FRAC_BITS;
  localparam logic signed [33:0] ONE_IN = 34'sd1 <<< FRAC_BITS;
  localparam logic signed [33:0] TWO_IN = 34'sd2 <<< FRAC_BITS;
  localparam logic signed [64:0] SUM_MAX = {2'b00, MAG_MAX};
  localparam logic signed [64:0] SUM_MIN = -SUM_MAX;
  localparam logic [63:0] ONE_W = 64'd1 << WORK_FRAC_BITS;
  localparam logic [63:0] HALF_LSB = 64'd1 << (SH - 1);

  tsfu_state_t state, state_next;

  logic [7:0]         term_limit;
  logic [1:0]         kind;
  logic [62:0]        xm;
  logic               cs;
  logic [62:0]        cm;
  logic               bs;
  logic [62:0]        bm;
  logic               ps;
  logic [62:0]        pm;
  logic [DEN_W-1:0]   den;
  logic signed [63:0] sum;
  logic [7:0]         count;
  logic               launched;

  logic         mul_start, mul_done;
  logic [63:0]  mul_a, mul_b;
  logic [127:0] mul_prod;
  logic         div_start, div_done;
  logic [62:0]  div_q;

  // request decode
  logic               accept;
  logic signed [33:0] xin34;
  logic [31:0]        xin_mag;
  logic [67:0]        xin_sh;
  logic [62:0]        x_mag;
  logic               in_domain;
  logic signed [63:0] x_signed;
  logic signed [63:0] log_d;
  logic [7:0]         limit_eff;
  logic [8:0]         k2p1;
  logic [8:0]         k2;
  logic [62:0]        mulfix_mag;
  logic [62:0]        scale_mag;
  logic               stop_now;
  logic signed [63:0] c_next;
  logic signed [64:0] sum_wide;
  logic [63:0]        sum_mag;
  logic [63:0]        round_mag;
  logic [31:0]        round_out;

  assign accept  = start && !busy;
  assign xin34   = {{2{req.x_value[31]}}, req.x_value};
  assign xin_mag = req.x_value[31] ? 32'd0 - req.x_value : req.x_value;
  assign xin_sh  = {36'd0, xin_mag} << SH;
  assign x_mag   = (xin_sh > {5'd0, MAG_MAX}) ? MAG_MAX : xin_sh[62:0];
  assign x_signed = req.x_value[31] ? -$signed({1'b0, x_mag}) : $signed({1'b0, x_mag});
  assign log_d   = x_signed - $signed(ONE_W);

  always_comb begin
    case (req.kind)
      KIND_SIN:  in_domain = 1'b1;
      KIND_ATAN: in_domain = (xin34 > -ONE_IN) && (xin34 < ONE_IN);
      KIND_LOG:  in_domain = (xin34 > 34'sd0) && (xin34 < TWO_IN);
      default:   in_domain = 1'b0;
    endcase
  end

  assign limit_eff = (term_limit == 8'd0) ? 8'd1 : term_limit;
  assign k2        = {count, 1'b0};
  assign k2p1      = {count, 1'b1};

  // products saturated; mulfix scaled back to the working format, scale kept as is
  assign mulfix_mag = (mul_prod[127:WORK_FRAC_BITS + 63] != '0) ? MAG_MAX
                    : mul_prod[WORK_FRAC_BITS +: 63];
  assign scale_mag  = (mul_prod[127:63] != '0) ? MAG_MAX : mul_prod[62:0];

  assign stop_now = (div_q == '0) || (count >= limit_eff);
  assign c_next   = ps ? $signed({1'b0, div_q}) : -$signed({1'b0, div_q});
  assign sum_wide = {sum[63], sum} + {c_next[63], c_next};

  assign sum_mag   = sum[63] ? 64'd0 - sum : sum;
  assign round_mag = (sum_mag + HALF_LSB) >> SH;
  always_comb begin
    if (sum[63]) begin
      round_out = (round_mag > 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - round_mag[31:0];
    end else begin
      round_out = (round_mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : round_mag[31:0];
    end
  end

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: one shared operation per state
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    mul_a      = {1'b0, cm};
    mul_b      = {1'b0, bm};
    unique case (state)
      ST_IDLE: begin
        if (accept && in_domain) begin
          state_next = (req.kind == KIND_LOG) ? ST_TERM : ST_X2;
        end
      end
      ST_X2: begin
        mul_a     = {1'b0, xm};
        mul_b     = {1'b0, xm};
        mul_start = !launched;
        if (mul_done) begin
          state_next = ST_TERM;
        end
      end
      ST_TERM: begin
        mul_start = !launched;
        if (mul_done) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        mul_a = {1'b0, pm};
        case (kind)
          KIND_ATAN: mul_b = {55'd0, k2 - 9'd1};
          KIND_LOG:  mul_b = {56'd0, count};
          default:   mul_b = 64'd1;
        endcase
        mul_start = !launched;
        if (mul_done) begin
          state_next = (kind == KIND_SIN) ? ST_DEN : ST_DIV;
        end
      end
      ST_DEN: begin
        mul_a     = {55'd0, k2p1};
        mul_b     = {55'd0, k2};
        mul_start = !launched;
        if (mul_done) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        div_start = !launched;
        if (div_done) begin
          state_next = stop_now ? ST_ROUND : ST_TERM;
        end
      end
      ST_ROUND: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term_limit   <= 8'd64;
      launched     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        term_limit <= cfg_data;
      end
      if (mul_done || div_done) begin
        launched <= 1'b0;
      end else if (mul_start || div_start) begin
        launched <= 1'b1;
      end
      // strobe a domain reject at once, a series result after rounding
      result_valid <= (accept && !in_domain) || (state == ST_ROUND);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      kind  <= req.kind;
      xm    <= x_mag;
      count <= 8'd1;
      if (!in_domain) begin
        result.result_value <= '0;
        result.status       <= STAT_DOMAIN;
      end
      if (req.kind == KIND_LOG) begin
        cs  <= log_d[63];
        cm  <= log_d[63] ? 63'(64'd0 - log_d) : log_d[62:0];
        bs  <= log_d[63];
        bm  <= log_d[63] ? 63'(64'd0 - log_d) : log_d[62:0];
        sum <= log_d;
      end else begin
        cs  <= req.x_value[31];
        cm  <= x_mag;
        bs  <= 1'b0;
        sum <= x_signed;
      end
    end
    if (state == ST_X2 && mul_done) begin
      bm <= mulfix_mag;
    end
    if (state == ST_TERM && mul_done) begin
      pm <= mulfix_mag;
      ps <= cs ^ bs;
    end
    if (state == ST_SCALE && mul_done) begin
      pm <= scale_mag;
      case (kind)
        KIND_ATAN: den <= DEN_W'(k2p1);
        KIND_LOG:  den <= DEN_W'({1'b0, count} + 9'd1);
        default:   den <= '0;
      endcase
    end
    if (state == ST_DEN && mul_done) begin
      den <= mul_prod[DEN_W-1:0];
    end
    if (state == ST_DIV && div_done) begin
      if (!stop_now) begin
        cs    <= !ps;
        cm    <= div_q;
        count <= count + 8'd1;
        if (sum_wide > SUM_MAX) begin
          sum <= SUM_MAX[63:0];
        end else if (sum_wide < SUM_MIN) begin
          sum <= SUM_MIN[63:0];
        end else begin
          sum <= sum_wide[63:0];
        end
      end else begin
        result.status <= (div_q == '0) ? STAT_CONV : STAT_LIMIT;
      end
    end
    if (state == ST_ROUND) begin
      result.result_value <= round_out;
    end
  end

  tsfu_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  tsfu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (pm),
    .divisor  (den),
    .done     (div_done),
    .quo      (div_q)
  );

endmodule

// ===== src/tsfu_mul.sv =====
// ----------------------------------------------------------------------------
// tsfu_mul
// 64x64 unsigned multiply on one 32x32 multiplier, one partial per cycle.
// ----------------------------------------------------------------------------
module tsfu_mul import tsfu_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  output logic          done,
  output logic [127:0]  prod
);

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [2:0]   step;
  logic         active;
  logic [63:0]  pp;
  logic [1:0]   pp_idx;
  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [6:0]   pp_sh;

  assign a_half = step[1] ? a_r[63:32] : a_r[31:0];
  assign b_half = step[0] ? b_r[63:32] : b_r[31:0];
  assign pp_sh  = {({1'b0, pp_idx[1]} + {1'b0, pp_idx[0]}), 5'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= !start && active && (step == 3'd4);
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        step   <= '0;
        active <= 1'b1;
        prod   <= '0;
      end else if (active) begin
        // issue one partial product, fold in the one from last cycle
        if (step != 3'd4) begin
          pp     <= a_half * b_half;
          pp_idx <= step[1:0];
        end
        if (step != 3'd0) begin
          prod <= prod + ({64'd0, pp} << pp_sh);
        end
        if (step == 3'd4) begin
          active <= 1'b0;
        end
        step <= step + 3'd1;
      end
    end
  end

endmodule

// ===== src/tsfu_div.sv =====
// ----------------------------------------------------------------------------
// tsfu_div
// Restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module tsfu_div import tsfu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [62:0]       dividend,
  input  logic [DEN_W-1:0]  divisor,
  output logic              done,
  output logic [62:0]       quo
);

  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem;
  logic [5:0]       cnt;
  logic             active;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem[DEN_W-1:0], quo[62]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= !start && active && (cnt == 6'd62);
      if (start) begin
        den_r  <= divisor;
        quo    <= dividend;
        rem    <= '0;
        cnt    <= '0;
        active <= 1'b1;
      end else if (active) begin
        rem <= fits ? trial - {1'b0, den_r} : trial;
        quo <= {quo[61:0], fits};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd62) begin
          active <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== src/tsfu_checker.sv =====
// ----------------------------------------------------------------------------
// tsfu_checker
// Port-level checks of the request and result channels.
// ----------------------------------------------------------------------------
`include "taylor_series_function_unit_assert.svh"

module tsfu_checker import tsfu_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       result_valid,
  input tsfu_res_t  result,
  input logic       cfg_ready
);

  `TSFU_ASSERT_NOW(a_strobe_idle, result_valid, !busy)
  `TSFU_ASSERT_NEXT(a_req_taken, start && !busy, busy || result_valid)
  `TSFU_ASSERT_NOW(a_domain_zero, result_valid && result.status == STAT_DOMAIN, result.result_value == 32'sd0)
  `TSFU_ASSERT_NOW(a_cfg_idle, cfg_ready, !busy)

endmodule

bind taylor_series_function_unit tsfu_checker u_tsfu_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result),
  .cfg_ready    (cfg_ready)
);
